/* rtl/core/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// shared types, constants and helpers of the byte ring fifo with claim lock
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned MemDepth = 256;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned SizeW    = 9;
  localparam int unsigned SizeCap  = (MemDepth < 256) ? MemDepth : 256;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [SizeW-1:0] size_t;

  typedef enum logic [2:0] {
    OpWrite  = 3'd0,
    OpRead   = 3'd1,
    OpClaim  = 3'd2,
    OpLock   = 3'd3,
    OpUnlock = 3'd4,
    OpFill   = 3'd5
  } brf_op_e;

  typedef struct packed {
    logic       wr_en;
    addr_t      wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    addr_t      rd_addr;
  } brf_mem_req_t;

  typedef struct packed {
    logic       ok;
    logic       rd_ok;
    logic [7:0] slot_out;
    logic       can_read;
    logic       can_write;
  } brf_result_t;

  function automatic size_t brf_clamp(input size_t v);
    size_t r;
    r = v;
    if (v == '0) begin
      r = size_t'(1);
    end else if (v > size_t'(SizeCap)) begin
      r = size_t'(SizeCap);
    end
    return r;
  endfunction

  function automatic addr_t brf_advance(input addr_t p, input size_t size);
    size_t n;
    n = {1'b0, p} + size_t'(1);
    return (n >= size) ? '0 : n[AddrW-1:0];
  endfunction

endpackage

/* rtl/core/brf_in_if.sv */
// ----------------------------------------------------------------------------
// brf_in_if
// operation channel: op, data byte and slot index
// ----------------------------------------------------------------------------
interface brf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data_in;
  logic [7:0] slot;

  modport source (output valid, output op, output data_in, output slot, input ready);
  modport sink   (input valid, input op, input data_in, input slot, output ready);
endinterface

/* rtl/core/brf_out_if.sv */
// ----------------------------------------------------------------------------
// brf_out_if
// result channel: status, read byte, claimed slot and fill flags
// ----------------------------------------------------------------------------
interface brf_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] data_out;
  logic [7:0] slot_out;
  logic       can_read;
  logic       can_write;

  modport source (output valid, output ok, output data_out, output slot_out,
                  output can_read, output can_write, input ready);
  modport sink   (input valid, input ok, input data_out, input slot_out,
                  input can_read, input can_write, output ready);
endinterface

/* rtl/core/brf_cfg_if.sv */
// ----------------------------------------------------------------------------
// brf_cfg_if
// configuration write channel for the buffer size register
// ----------------------------------------------------------------------------
interface brf_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] buffer_size;

  modport source (output valid, output buffer_size, input ready);
  modport sink   (input valid, input buffer_size, output ready);
endinterface

/* rtl/core/brf_mem.sv */
// ----------------------------------------------------------------------------
// brf_mem
// byte store: one write port and one registered read port
// ----------------------------------------------------------------------------
module brf_mem (
  input  logic                  clk_i,
  input  brf_pkg::brf_mem_req_t req_i,
  output logic [7:0]            rd_data_o
);
  import brf_pkg::*;

  logic [7:0] mem_q [MemDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/brf_ctrl.sv */
// ----------------------------------------------------------------------------
// brf_ctrl
// ring pointers, free count and lock slot; decides each word in one pass
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  brf_pkg::size_t        cfg_size_i,
  input  logic                  accept_i,
  input  logic [2:0]            op_i,
  input  logic [7:0]            data_in_i,
  input  logic [7:0]            slot_i,
  output brf_pkg::brf_mem_req_t mem_req_o,
  output brf_pkg::brf_result_t  result_o
);
  import brf_pkg::*;

  size_t size_q, size_d;
  size_t free_q, free_d;
  addr_t head_q, head_d;
  addr_t tail_q, tail_d;
  logic  lock_q, lock_d;
  addr_t lock_idx_q, lock_idx_d;

  logic can_push, can_pop, slot_ok;

  always_comb begin
    can_push = (free_q != '0) && !(lock_q && (lock_idx_q == head_q));
    can_pop  = (free_q != size_q) && !(lock_q && (lock_idx_q == tail_q));
    slot_ok  = ({1'b0, slot_i} < size_q);

    size_d     = size_q;
    free_d     = free_q;
    head_d     = head_q;
    tail_d     = tail_q;
    lock_d     = lock_q;
    lock_idx_d = lock_idx_q;

    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = head_q;
    mem_req_o.wr_data = data_in_i;
    mem_req_o.rd_en   = 1'b0;
    mem_req_o.rd_addr = tail_q;

    result_o.ok       = 1'b0;
    result_o.rd_ok    = 1'b0;
    result_o.slot_out = '0;

    if (cfg_we_i) begin
      size_d     = brf_clamp(cfg_size_i);
      free_d     = size_d;
      head_d     = '0;
      tail_d     = '0;
      lock_d     = 1'b0;
      lock_idx_d = '0;
    end else if (accept_i) begin
      case (brf_op_e'(op_i))
        OpWrite: begin
          if (can_push) begin
            mem_req_o.wr_en = 1'b1;
            head_d          = brf_advance(head_q, size_q);
            free_d          = free_q - size_t'(1);
            result_o.ok     = 1'b1;
          end
        end
        OpRead: begin
          if (can_pop) begin
            mem_req_o.rd_en = 1'b1;
            tail_d          = brf_advance(tail_q, size_q);
            free_d          = free_q + size_t'(1);
            result_o.ok     = 1'b1;
            result_o.rd_ok  = 1'b1;
          end
        end
        OpClaim: begin
          if (can_push) begin
            result_o.slot_out = head_q;
            if (!lock_q) begin
              lock_d     = 1'b1;
              lock_idx_d = head_q;
            end
            head_d      = brf_advance(head_q, size_q);
            free_d      = free_q - size_t'(1);
            result_o.ok = 1'b1;
          end
        end
        OpLock: begin
          if (slot_ok) begin
            lock_d      = 1'b1;
            lock_idx_d  = slot_i;
            result_o.ok = 1'b1;
          end
        end
        OpUnlock: begin
          lock_d      = 1'b0;
          lock_idx_d  = '0;
          result_o.ok = 1'b1;
        end
        OpFill: begin
          if (slot_ok) begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = slot_i;
            result_o.ok       = 1'b1;
          end
        end
        default: ;
      endcase
    end

    result_o.can_read  = (free_d != size_d);
    result_o.can_write = (free_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= size_t'(SizeCap);
      free_q     <= size_t'(SizeCap);
      head_q     <= '0;
      tail_q     <= '0;
      lock_q     <= 1'b0;
      lock_idx_q <= '0;
    end else begin
      size_q     <= size_d;
      free_q     <= free_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      lock_q     <= lock_d;
      lock_idx_q <= lock_idx_d;
    end
  end

  a_free_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= size_q)
    else $error("free count above buffer size");

  a_head_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < size_q)
    else $error("head outside ring");

  a_tail_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, tail_q} < size_q)
    else $error("tail outside ring");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !cfg_we_i && free_q == '0) |-> !(result_o.ok && !mem_req_o.rd_en
      && (op_i == OpWrite || op_i == OpClaim)))
    else $error("push accepted on full ring");

endmodule

/* rtl/core/byte_ring_fifo_with_claim_lock_unit.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_claim_lock_unit
// circular byte fifo with claim, one lock slot and slot fill
// ----------------------------------------------------------------------------
// result: registered, and shown in the cycle after the word is accepted
// throughput: one word per cycle unless a stalled result or a size write blocks,
//   set by the single-pass pointer update and the one-write, one-read byte store
// reset: pointers, lock and output valid clear; size returns to 256
// byte store contents are not reset
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_claim_lock_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  brf_cfg_if.sink   cfg_i,
  brf_in_if.sink    in_i,
  brf_out_if.source out_o
);
  import brf_pkg::*;

  logic         accept;
  logic         cfg_we;
  brf_mem_req_t mem_req;
  brf_result_t  result;
  logic [7:0]   rd_data;

  logic         out_valid_q;
  brf_result_t  res_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign in_i.ready  = (!out_valid_q || out_o.ready) && !cfg_i.valid;
  assign accept      = in_i.valid && in_i.ready;

  brf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_size_i (cfg_i.buffer_size),
    .accept_i   (accept),
    .op_i       (in_i.op),
    .data_in_i  (in_i.data_in),
    .slot_i     (in_i.slot),
    .mem_req_o  (mem_req),
    .result_o   (result)
  );

  brf_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ok        = res_q.ok;
  assign out_o.data_out  = res_q.rd_ok ? rd_data : 8'd0;
  assign out_o.slot_out  = res_q.slot_out;
  assign out_o.can_read  = res_q.can_read;
  assign out_o.can_write = res_q.can_write;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result stalled");

  a_read_data_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.rd_ok) |-> (out_o.data_out == 8'd0))
    else $error("data out on non-read result");

endmodule

/* verif/byte_ring_fifo_with_claim_lock_unit_tb.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_claim_lock_unit_tb
// self-checking testbench of the byte ring fifo with claim lock
// ----------------------------------------------------------------------------
// words are planned against a shadow copy of the ring, so that no read ever
// reaches a slot that was never written, then driven with random gaps. each
// accepted word is stepped through a ring predictor and the expected status
// word is checked against the result channel. the size register is written
// between phases while the unit is idle, from the smallest ring to the full
// 256 slots and with out-of-range values.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_claim_lock_unit_tb;
  import brf_pkg::*;

  localparam logic [2:0] OpSpareA   = 3'd6;
  localparam logic [2:0] OpSpareB   = 3'd7;
  localparam int         QuietLimit = 2000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic [7:0] slot;
  } fifo_word_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] data_out;
    logic [7:0] slot_out;
    logic       can_read;
    logic       can_write;
  } fifo_result_t;

  typedef struct packed {
    logic [MemDepth-1:0][7:0] bytes;
    logic [MemDepth-1:0]      filled;
    addr_t                    head;
    addr_t                    tail;
    size_t                    free_cnt;
    logic                     lock_held;
    addr_t                    lock_idx;
    size_t                    size;
  } ring_state_t;

  logic clk_i;
  logic rst_ni;

  brf_cfg_if cfg_bus ();
  brf_in_if  op_bus ();
  brf_out_if res_bus ();

  byte_ring_fifo_with_claim_lock_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (op_bus),
    .out_o  (res_bus)
  );

  ring_state_t  ring_model;
  ring_state_t  ring_plan;
  fifo_word_t   queued_words[$];
  fifo_result_t expected_status[$];
  fifo_result_t want;
  fifo_result_t got;
  int           mismatches   = 0;
  int           quiet_cycles = 0;
  int           op_gap       = 0;
  int           rdy_gap      = 0;
  logic         op_taken     = 1'b0;
  bit           hold_ops     = 1'b0;
  bit           idle_mode    = 1'b0;
  bit           calm         = 1'b0;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic size_t clamp_size(input logic [8:0] v);
    if (v == '0) return size_t'(1);
    if (v > size_t'(SizeCap)) return size_t'(SizeCap);
    return v;
  endfunction

  function automatic addr_t ring_next(input addr_t p, input size_t sz);
    size_t n;
    n = {1'b0, p} + size_t'(1);
    return (n >= sz) ? '0 : n[AddrW-1:0];
  endfunction

  function automatic void ring_resize(inout ring_state_t s, input logic [8:0] v);
    s.size      = clamp_size(v);
    s.head      = '0;
    s.tail      = '0;
    s.free_cnt  = s.size;
    s.lock_held = 1'b0;
    s.lock_idx  = '0;
  endfunction

  function automatic fifo_result_t ring_step(inout ring_state_t s, input fifo_word_t w);
    fifo_result_t r;
    r = '0;
    case (w.op)
      OpWrite: begin
        if (s.free_cnt != 0 && !(s.lock_held && s.lock_idx == s.head)) begin
          s.bytes[s.head]  = w.data;
          s.filled[s.head] = 1'b1;
          s.head           = ring_next(s.head, s.size);
          s.free_cnt       = s.free_cnt - size_t'(1);
          r.ok             = 1'b1;
        end
      end
      OpRead: begin
        if (s.free_cnt != s.size && !(s.lock_held && s.lock_idx == s.tail)) begin
          r.data_out = s.bytes[s.tail];
          s.tail     = ring_next(s.tail, s.size);
          s.free_cnt = s.free_cnt + size_t'(1);
          r.ok       = 1'b1;
        end
      end
      OpClaim: begin
        if (s.free_cnt != 0 && !(s.lock_held && s.lock_idx == s.head)) begin
          r.slot_out = s.head;
          if (!s.lock_held) begin
            s.lock_held = 1'b1;
            s.lock_idx  = s.head;
          end
          s.head     = ring_next(s.head, s.size);
          s.free_cnt = s.free_cnt - size_t'(1);
          r.ok       = 1'b1;
        end
      end
      OpLock: begin
        if ({1'b0, w.slot} < s.size) begin
          s.lock_held = 1'b1;
          s.lock_idx  = w.slot;
          r.ok        = 1'b1;
        end
      end
      OpUnlock: begin
        s.lock_held = 1'b0;
        s.lock_idx  = '0;
        r.ok        = 1'b1;
      end
      OpFill: begin
        if ({1'b0, w.slot} < s.size) begin
          s.bytes[w.slot]  = w.data;
          s.filled[w.slot] = 1'b1;
          r.ok             = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.can_read  = (s.free_cnt != s.size);
    r.can_write = (s.free_cnt != 0);
    return r;
  endfunction

  // a read that would reach a never-written slot becomes a fill of that slot
  function automatic fifo_result_t queue_op(input logic [2:0] op, input logic [7:0] data,
                                            input logic [7:0] slot);
    fifo_word_t w;
    w = {op, data, slot};
    if (op == OpRead && ring_plan.free_cnt != ring_plan.size &&
        !(ring_plan.lock_held && ring_plan.lock_idx == ring_plan.tail) &&
        !ring_plan.filled[ring_plan.tail]) begin
      w.op   = OpFill;
      w.slot = ring_plan.tail;
    end
    queued_words.push_back(w);
    return ring_step(ring_plan, w);
  endfunction

  task automatic rand_item(input int w_pct);
    int           roll;
    logic [7:0]   d;
    logic [7:0]   s;
    logic [7:0]   in_range;
    fifo_result_t r;
    d        = 8'($urandom);
    s        = 8'($urandom);
    in_range = 8'($urandom_range(0, ring_plan.size - 1));
    roll     = $urandom_range(0, 99);
    if (roll < w_pct) begin
      void'(queue_op(OpWrite, d, s));
    end else if (roll < 70) begin
      void'(queue_op(OpRead, d, s));
    end else if (roll < 78) begin
      // claim, then mostly fill the claimed slot and sometimes release the lock
      r = queue_op(OpClaim, d, s);
      if (r.ok && $urandom_range(0, 3) != 0) begin
        void'(queue_op(OpFill, 8'($urandom), r.slot_out));
        if ($urandom_range(0, 1) == 1) void'(queue_op(OpUnlock, d, s));
      end
    end else if (roll < 87) begin
      void'(queue_op(OpFill, d, ($urandom_range(0, 1) == 1) ? in_range : s));
    end else if (roll < 92) begin
      void'(queue_op(OpLock, d, ($urandom_range(0, 3) != 0) ? in_range : s));
    end else if (roll < 98) begin
      void'(queue_op(OpUnlock, d, s));
    end else begin
      void'(queue_op(($urandom_range(0, 1) == 1) ? OpSpareA : OpSpareB, d, s));
    end
  endtask

  task automatic settle();
    while (queued_words.size() != 0 || expected_status.size() != 0 || op_bus.valid)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [8:0] v);
    settle();
    @(negedge clk_i);
    cfg_bus.buffer_size <= v;
    cfg_bus.valid       <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    ring_resize(ring_plan, v);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic hold_sender();
    while (queued_words.size() > 20) @(posedge clk_i);
    hold_ops = 1'b1;
    while (expected_status.size() != 0 || op_bus.valid) @(posedge clk_i);
    hold_ops = 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] sz, input int n_items, input bit pause_once,
                           input bit fill_first);
    int k;
    int w_pct;
    set_size(sz);
    if (fill_first) begin
      while (ring_plan.free_cnt != 0) void'(queue_op(OpWrite, 8'($urandom), 8'($urandom)));
    end
    w_pct = 40;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        while (queued_words.size() > 8) @(posedge clk_i);
        idle_mode = !calm && ($urandom_range(0, 3) != 0);
        w_pct     = 10 + 10 * $urandom_range(0, 5);
      end
      if (k % 40 == 20 && (pause_once || $urandom_range(0, 3) == 0)) hold_sender();
      rand_item(w_pct);
    end
  endtask

  // word driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      op_bus.valid <= 1'b0;
    end else if (op_bus.valid && !op_taken) begin
    end else if (op_gap != 0) begin
      op_gap       <= op_gap - 1;
      op_bus.valid <= 1'b0;
    end else if (queued_words.size() == 0 || hold_ops) begin
      op_bus.valid <= 1'b0;
    end else if (idle_mode && $urandom_range(0, 5) == 0) begin
      op_gap       <= $urandom_range(0, 7);
      op_bus.valid <= 1'b0;
    end else begin
      op_bus.valid   <= 1'b1;
      op_bus.op      <= queued_words[0].op;
      op_bus.data_in <= queued_words[0].data;
      op_bus.slot    <= queued_words[0].slot;
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else if (rdy_gap != 0) begin
      rdy_gap       <= rdy_gap - 1;
      res_bus.ready <= 1'b0;
    end else if (idle_mode && $urandom_range(0, 5) == 0) begin
      rdy_gap       <= $urandom_range(0, 7);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  // monitor and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      op_taken <= 1'b0;
    end else begin
      op_taken <= op_bus.valid && op_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) ring_resize(ring_model, cfg_bus.buffer_size);
      if (res_bus.valid && res_bus.ready) begin
        got = {res_bus.ok, res_bus.data_out, res_bus.slot_out, res_bus.can_read,
               res_bus.can_write};
        if (expected_status.size() == 0) begin
          flag_error($sformatf("unexpected result word ok=%0b data=%02h slot=%02h",
                               got.ok, got.data_out, got.slot_out));
        end else begin
          want = expected_status.pop_front();
          if (got.ok !== want.ok || got.data_out !== want.data_out ||
              got.slot_out !== want.slot_out || got.can_read !== want.can_read ||
              got.can_write !== want.can_write) begin
            flag_error($sformatf({"result mismatch: expected ok=%0b data=%02h slot=%02h ",
                                  "rd=%0b wr=%0b, got ok=%0b data=%02h slot=%02h ",
                                  "rd=%0b wr=%0b"},
                                 want.ok, want.data_out, want.slot_out, want.can_read,
                                 want.can_write, got.ok, got.data_out, got.slot_out,
                                 got.can_read, got.can_write));
          end
        end
      end
      if (op_bus.valid && op_bus.ready) begin
        expected_status.push_back(ring_step(ring_model,
                                            {op_bus.op, op_bus.data_in, op_bus.slot}));
        void'(queued_words.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("byte_ring_fifo_with_claim_lock_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    op_bus.valid        = 1'b0;
    op_bus.op           = '0;
    op_bus.data_in      = '0;
    op_bus.slot         = '0;
    res_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.buffer_size = '0;
    ring_model          = '0;
    ring_resize(ring_model, 9'd256);
    ring_plan           = ring_model;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full-size ring out of reset
    void'(queue_op(OpUnlock, 8'h00, 8'h00));
    void'(queue_op(OpSpareA, 8'hff, 8'hff));
    void'(queue_op(OpSpareB, 8'h3c, 8'h81));
    void'(queue_op(OpRead, 8'h00, 8'h00));
    void'(queue_op(OpWrite, 8'h00, 8'hff));
    void'(queue_op(OpWrite, 8'hff, 8'h00));
    void'(queue_op(OpClaim, 8'h11, 8'h22));
    void'(queue_op(OpWrite, 8'h5a, 8'h00));
    void'(queue_op(OpRead, 8'h00, 8'h00));
    void'(queue_op(OpRead, 8'h00, 8'h00));
    void'(queue_op(OpRead, 8'h00, 8'h00));
    void'(queue_op(OpFill, 8'ha5, 8'h02));
    void'(queue_op(OpLock, 8'h00, 8'h04));
    void'(queue_op(OpWrite, 8'h77, 8'h00));
    void'(queue_op(OpClaim, 8'h00, 8'h00));
    void'(queue_op(OpRead, 8'h00, 8'h00));
    void'(queue_op(OpRead, 8'h00, 8'h00));
    void'(queue_op(OpLock, 8'h00, 8'hff));

    // slots past the ring size
    set_size(9'd3);
    void'(queue_op(OpLock, 8'h00, 8'h03));
    void'(queue_op(OpFill, 8'h99, 8'hff));

    // single-slot ring
    set_size(9'd1);
    void'(queue_op(OpWrite, 8'hff, 8'h00));
    void'(queue_op(OpWrite, 8'h00, 8'h00));
    void'(queue_op(OpRead, 8'h00, 8'h00));
    void'(queue_op(OpRead, 8'h00, 8'h00));

    run_phase(9'd2, 80, 1'b1, 1'b0);
    run_phase(9'd3, 80, 1'b0, 1'b0);
    run_phase(9'd0, 60, 1'b0, 1'b0);
    run_phase(9'd5, 80, 1'b0, 1'b1);
    run_phase(9'd511, 60, 1'b0, 1'b0);
    run_phase(9'd256, 150, 1'b0, 1'b1);
    run_phase(9'd17, 80, 1'b0, 1'b0);
    run_phase(9'd300, 60, 1'b0, 1'b0);
    run_phase(9'($urandom_range(1, 511)), 80, 1'b0, 1'b0);
    calm      = 1'b1;
    idle_mode = 1'b0;
    run_phase(9'd8, 80, 1'b0, 1'b1);

    settle();
    repeat (3) @(posedge clk_i);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("byte_ring_fifo_with_claim_lock_unit regression: pass");
    end else begin
      $display("byte_ring_fifo_with_claim_lock_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/brf_pkg.sv
rtl/core/brf_in_if.sv
rtl/core/brf_out_if.sv
rtl/core/brf_cfg_if.sv
rtl/core/brf_mem.sv
rtl/core/brf_ctrl.sv
rtl/core/byte_ring_fifo_with_claim_lock_unit.sv
verif/byte_ring_fifo_with_claim_lock_unit_tb.sv
